// ===== design/diameter_avp_search_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Diameter AVP search core
// Concurrent checks clocked on i_clk; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIAMETER_AVP_SEARCH_CORE_ASSERT_SVH
`define DIAMETER_AVP_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property outside of reset
`define DAVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check a property at every edge, reset included
`define DAVP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define DAVP_ASSERT(lbl, prop, msg)
`define DAVP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/davp_pkg.sv =====
// ----------------------------------------------------------------------------
// Diameter AVP search package
// Shared types and constants of the AVP search core and its parser.
// ----------------------------------------------------------------------------
package davp_pkg;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_AVPHDR = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_CODE   = 2'd0;
    localparam logic [1:0] CFG_TARGET_VENDOR = 2'd1;
    localparam logic [1:0] CFG_WHOLE_AVP     = 2'd2;

    // Message and AVP header layout
    localparam logic [3:0] MSG_HDR_LAST_IDX = 4'd15;
    localparam logic [4:0] AVP_HDR_LEN      = 5'd8;
    localparam logic [4:0] AVP_HDR_VND_LEN  = 5'd12;
    localparam int         VENDOR_BIT       = 7;
    localparam logic [23:0] LEN_MAX         = 24'hFF_FFFF;

    typedef struct packed {
        logic [31:0] target_code;
        logic [31:0] target_vendor;
        logic        whole_avp;
    } t_cfg;

    typedef struct packed {
        logic [31:0] application_id;
        logic [23:0] command_code;
        logic [7:0]  command_flags;
        logic [23:0] span_length;
        logic [23:0] span_offset;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== design/diameter_avp_search_core.sv =====
// ----------------------------------------------------------------------------
// Diameter AVP search core
// Parses a Diameter message body byte by byte and reports the first AVP that
// matches the configured code and vendor id.
//
//   Channel   Dir   Handshake              Payload
//   s_*       in    s_tvalid / s_tready    tdata: data_byte; tlast: last_byte
//   m_*       out   m_tvalid / m_tready    tuser: status; tdata: span and header
//   i_cfg_*   in    i_cfg_we               index 0 code, 1 vendor, 2 whole mode
//
// One byte per cycle while no result stalls: an input register feeds the
// parser, which updates its state and fills the result register in the same
// cycle. A result is registered when the parser consumes the byte that causes
// it. A stalled result holds the parser; the input register then fills and
// s_tready drops. Synchronous active-low reset clears flags, config and parser.
// ----------------------------------------------------------------------------
module diameter_avp_search_core #(
    parameter int POSITION_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input bytes
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tlast,
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // span_offset, span_length, command_flags,
                                     // command_code, application_id
    output logic [1:0]    m_tuser,   // [1:0] status
    // Configuration writes
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    davp_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    davp_pkg::t_result r_out;

    logic              w_step;
    logic              w_res_valid;
    davp_pkg::t_result w_res;

    // Consume the held byte when the result register can take a result
    assign w_step   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                davp_pkg::CFG_TARGET_CODE:   r_cfg.target_code   <= i_cfg_data;
                davp_pkg::CFG_TARGET_VENDOR: r_cfg.target_vendor <= i_cfg_data;
                davp_pkg::CFG_WHOLE_AVP:     r_cfg.whole_avp     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    davp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {r_out.application_id, r_out.command_code, r_out.command_flags,
                       r_out.span_length, r_out.span_offset};

endmodule

// ===== design/davp_parser.sv =====
// ----------------------------------------------------------------------------
// Diameter AVP parser
// Per-byte message state and AVP walk; gives at most one result per byte.
// ----------------------------------------------------------------------------
`include "diameter_avp_search_core_assert.svh"

module davp_parser #(
    parameter int POSITION_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  davp_pkg::t_cfg   i_cfg,
    output logic             o_res_valid,
    output davp_pkg::t_result o_res
);

    davp_pkg::t_phase         r_phase, n_phase;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_avp_start, n_avp_start;
    logic [3:0]               r_idx, n_idx;
    logic [7:0]               r_hflags, n_hflags;
    logic [23:0]              r_hcmd, n_hcmd;
    logic [31:0]              r_happ, n_happ;
    logic [31:0]              r_code, n_code;
    logic                     r_vflag, n_vflag;
    logic [23:0]              r_len, n_len;
    logic [31:0]              r_vendor, n_vendor;
    logic [23:0]              r_skip, n_skip;

    logic [POSITION_BITS-1:0] w_next_pos;
    logic [4:0]               w_hdr_len;
    logic [23:0]              w_vlen;
    logic [1:0]               w_pad;
    logic [23:0]              w_vlen_pad;
    logic [24:0]              w_total;
    logic                     w_hdr_done;
    logic                     w_match;

    function automatic logic [4:0] AVP_HDR_LEN_SEL(input logic vflag);
        return vflag ? davp_pkg::AVP_HDR_VND_LEN : davp_pkg::AVP_HDR_LEN;
    endfunction

    assign w_next_pos = r_pos + POSITION_BITS'(1);

    // Advance the parse by one byte
    always_comb begin
        n_phase     = r_phase;
        n_pos       = w_next_pos;
        n_avp_start = r_avp_start;
        n_idx       = r_idx;
        n_hflags    = r_hflags;
        n_hcmd      = r_hcmd;
        n_happ      = r_happ;
        n_code      = r_code;
        n_vflag     = r_vflag;
        n_len       = r_len;
        n_vendor    = r_vendor;
        n_skip      = r_skip;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_hdr_len   = AVP_HDR_LEN_SEL(1'b0);
        w_vlen      = '0;
        w_pad       = '0;
        w_vlen_pad  = '0;
        w_total     = '0;
        w_hdr_done  = 1'b0;
        w_match     = 1'b0;

        case (r_phase)
            davp_pkg::PH_HEADER: begin
                if (r_idx == 4'd0) begin
                    n_hflags = i_byte;
                end else if (r_idx <= 4'd3) begin
                    n_hcmd = {r_hcmd[15:0], i_byte};
                end else if (r_idx <= 4'd7) begin
                    n_happ = {r_happ[23:0], i_byte};
                end
                if (r_idx == davp_pkg::MSG_HDR_LAST_IDX) begin
                    n_phase     = davp_pkg::PH_AVPHDR;
                    n_idx       = '0;
                    n_avp_start = w_next_pos;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            davp_pkg::PH_AVPHDR: begin
                // Shift in code, flags, length and vendor id
                if (r_idx == 4'd0) begin
                    n_vendor = '0;
                end
                if (r_idx <= 4'd3) begin
                    n_code = {r_code[23:0], i_byte};
                end else if (r_idx == 4'd4) begin
                    n_vflag = i_byte[davp_pkg::VENDOR_BIT];
                end else if (r_idx <= 4'd7) begin
                    n_len = {r_len[15:0], i_byte};
                end else begin
                    n_vendor = {r_vendor[23:0], i_byte};
                end
                w_hdr_len  = AVP_HDR_LEN_SEL(n_vflag);
                w_hdr_done = ({1'b0, r_idx} + 5'd1) >= w_hdr_len;
                w_vlen     = n_len - {19'd0, w_hdr_len};
                w_pad      = 2'd0 - w_vlen[1:0];
                w_vlen_pad = w_vlen + {22'd0, w_pad};
                w_total    = {1'b0, n_len} + {23'd0, w_pad};
                w_match    = (n_code == i_cfg.target_code) &&
                             (n_vendor == i_cfg.target_vendor);
                if (w_hdr_done) begin
                    if (n_len < {19'd0, w_hdr_len}) begin
                        o_res_valid       = 1'b1;
                        o_res.status      = davp_pkg::ST_MALFORMED;
                        o_res.span_offset = 24'(r_avp_start);
                        o_res.span_length = n_len;
                        n_phase           = davp_pkg::PH_DONE;
                    end else if (w_match) begin
                        o_res_valid  = 1'b1;
                        o_res.status = davp_pkg::ST_FOUND;
                        if (i_cfg.whole_avp) begin
                            o_res.span_offset = 24'(r_avp_start);
                            o_res.span_length = w_total[24] ? davp_pkg::LEN_MAX
                                                            : w_total[23:0];
                        end else begin
                            o_res.span_offset = 24'(w_next_pos);
                            o_res.span_length = w_vlen;
                        end
                        n_phase = davp_pkg::PH_DONE;
                    end else if (w_vlen_pad == 24'd0) begin
                        n_phase     = davp_pkg::PH_AVPHDR;
                        n_idx       = '0;
                        n_avp_start = w_next_pos;
                    end else begin
                        n_skip  = w_vlen_pad;
                        n_phase = davp_pkg::PH_SKIP;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            davp_pkg::PH_SKIP: begin
                // Drop value and padding bytes
                n_skip = r_skip - 24'd1;
                if (n_skip == 24'd0) begin
                    n_phase     = davp_pkg::PH_AVPHDR;
                    n_idx       = '0;
                    n_avp_start = w_next_pos;
                end
            end
            davp_pkg::PH_DONE: begin
            end
            default: begin
                n_phase = davp_pkg::PH_DONE;
            end
        endcase

        // Header fields as they stand after this byte
        o_res.command_flags  = n_hflags;
        o_res.command_code   = n_hcmd;
        o_res.application_id = n_happ;

        // End of message: report not found unless a result was given, and clear the message state
        if (i_last) begin
            if (!o_res_valid && (r_phase != davp_pkg::PH_DONE)) begin
                o_res_valid       = 1'b1;
                o_res.status      = davp_pkg::ST_NOT_FOUND;
                o_res.span_offset = '0;
                o_res.span_length = '0;
            end
            n_phase     = davp_pkg::PH_HEADER;
            n_pos       = '0;
            n_avp_start = '0;
            n_idx       = '0;
            n_hflags    = '0;
            n_hcmd      = '0;
            n_happ      = '0;
            n_code      = '0;
            n_vflag     = 1'b0;
            n_len       = '0;
            n_vendor    = '0;
            n_skip      = '0;
        end
    end

    // Hold state until a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= davp_pkg::PH_HEADER;
            r_pos       <= '0;
            r_avp_start <= '0;
            r_idx       <= '0;
            r_hflags    <= '0;
            r_hcmd      <= '0;
            r_happ      <= '0;
            r_code      <= '0;
            r_vflag     <= 1'b0;
            r_len       <= '0;
            r_vendor    <= '0;
            r_skip      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_avp_start <= n_avp_start;
            r_idx       <= n_idx;
            r_hflags    <= n_hflags;
            r_hcmd      <= n_hcmd;
            r_happ      <= n_happ;
            r_code      <= n_code;
            r_vflag     <= n_vflag;
            r_len       <= n_len;
            r_vendor    <= n_vendor;
            r_skip      <= n_skip;
        end
    end

    // Checks
    `DAVP_ASSERT_ALWAYS(a_reset_header, !i_rst_n |=> r_phase == davp_pkg::PH_HEADER, "phase not header after reset")
    `DAVP_ASSERT(a_last_clears, i_step && i_last |=> r_phase == davp_pkg::PH_HEADER && r_pos == '0, "message state not cleared after last byte")
    `DAVP_ASSERT(a_hit_ends, i_step && o_res_valid && !i_last && o_res.status != davp_pkg::ST_NOT_FOUND |=> r_phase == davp_pkg::PH_DONE, "search not ended after result")
    `DAVP_ASSERT(a_done_quiet, i_step && !i_last && r_phase == davp_pkg::PH_DONE |-> !o_res_valid, "result after search ended")
    `DAVP_ASSERT(a_last_reports, i_step && i_last && r_phase != davp_pkg::PH_DONE |-> o_res_valid, "no result on last byte")

endmodule

// ===== test/diameter_avp_search_checker.sv =====
// ----------------------------------------------------------------------------
// Diameter AVP search checker
// Watches the byte, result and configuration channels of the search core. It
// keeps its own copy of the parser state and targets, predicts the report of
// every message, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module diameter_avp_search_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,   // span_offset, span_length, command_flags,
                                    // command_code, application_id
    input  logic [1:0]   m_tuser,   // [1:0] status
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_mismatches,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Search targets as last written
    davp_pkg::t_cfg     targets;

    // Message parse state
    logic [23:0]        pos;
    davp_pkg::t_phase   phase;
    logic [3:0]         idx;
    logic [7:0]         hdr_flags;
    logic [23:0]        hdr_cmd;
    logic [31:0]        hdr_app;
    logic [31:0]        avp_code;
    logic               avp_vflag;
    logic [23:0]        avp_len;
    logic [31:0]        avp_vendor;
    logic [23:0]        avp_begin;
    logic [31:0]        skip_left;
    logic               done;

    // Reports predicted but not yet seen on the result channel
    davp_pkg::t_result  awaited[$];

    function automatic void clear_message();
        pos        = '0;
        phase      = davp_pkg::PH_HEADER;
        idx        = '0;
        hdr_flags  = '0;
        hdr_cmd    = '0;
        hdr_app    = '0;
        avp_code   = '0;
        avp_vflag  = 1'b0;
        avp_len    = '0;
        avp_vendor = '0;
        avp_begin  = '0;
        skip_left  = '0;
        done       = 1'b0;
    endfunction

    function automatic void start_avp(input logic [23:0] at);
        phase     = davp_pkg::PH_AVPHDR;
        idx       = '0;
        avp_begin = at;
    endfunction

    function automatic davp_pkg::t_result make_report(input logic [1:0] st,
                                                      input logic [23:0] off,
                                                      input logic [23:0] len);
        davp_pkg::t_result r;
        r.status         = st;
        r.span_offset    = off;
        r.span_length    = len;
        r.command_flags  = hdr_flags;
        r.command_code   = hdr_cmd;
        r.application_id = hdr_app;
        return r;
    endfunction

    // Advance the parser by one body byte and queue the report it causes
    function automatic void parse_body_byte(input logic [7:0] b, input logic is_last);
        logic [23:0] nxt;
        logic [4:0]  hlen;
        logic [31:0] vlen;
        logic [31:0] pad;
        logic [31:0] total;
        logic        emitted;
        nxt     = pos + 24'd1;
        emitted = 1'b0;
        case (phase)
            davp_pkg::PH_HEADER: begin
                if (idx == 4'd0) hdr_flags = b;
                else if (idx <= 4'd3) hdr_cmd = {hdr_cmd[15:0], b};
                else if (idx <= 4'd7) hdr_app = {hdr_app[23:0], b};
                if (idx == davp_pkg::MSG_HDR_LAST_IDX) start_avp(nxt);
                else idx = idx + 4'd1;
            end
            davp_pkg::PH_AVPHDR: begin
                if (idx == 4'd0) avp_vendor = '0;
                if (idx <= 4'd3) avp_code = {avp_code[23:0], b};
                else if (idx == 4'd4) avp_vflag = b[davp_pkg::VENDOR_BIT];
                else if (idx <= 4'd7) avp_len = {avp_len[15:0], b};
                else avp_vendor = {avp_vendor[23:0], b};
                hlen = avp_vflag ? davp_pkg::AVP_HDR_VND_LEN : davp_pkg::AVP_HDR_LEN;
                if ({1'b0, idx} + 5'd1 >= hlen) begin
                    if (avp_len < 24'(hlen)) begin
                        awaited.push_back(make_report(davp_pkg::ST_MALFORMED, avp_begin,
                                                      avp_len));
                        emitted = 1'b1;
                        phase   = davp_pkg::PH_DONE;
                        done    = 1'b1;
                    end else begin
                        vlen = 32'(avp_len) - 32'(hlen);
                        pad  = (32'd4 - {30'd0, vlen[1:0]}) & 32'd3;
                        if (avp_code == targets.target_code &&
                            avp_vendor == targets.target_vendor) begin
                            if (targets.whole_avp) begin
                                // padded total saturates at the largest length
                                total = 32'(hlen) + vlen + pad;
                                if (total > 32'(davp_pkg::LEN_MAX))
                                    total = 32'(davp_pkg::LEN_MAX);
                                awaited.push_back(make_report(davp_pkg::ST_FOUND,
                                                              avp_begin, total[23:0]));
                            end else begin
                                awaited.push_back(make_report(davp_pkg::ST_FOUND, nxt,
                                                              vlen[23:0]));
                            end
                            emitted = 1'b1;
                            phase   = davp_pkg::PH_DONE;
                            done    = 1'b1;
                        end else if (vlen + pad == 32'd0) begin
                            start_avp(nxt);
                        end else begin
                            skip_left = vlen + pad;
                            phase     = davp_pkg::PH_SKIP;
                        end
                    end
                end else begin
                    idx = idx + 4'd1;
                end
            end
            davp_pkg::PH_SKIP: begin
                skip_left = {8'd0, skip_left[23:0] - 24'd1};
                if (skip_left == 32'd0) start_avp(nxt);
            end
            default: ;
        endcase
        pos = nxt;

        // End of body: report a miss unless the search already ended
        if (is_last) begin
            if (!emitted && !done)
                awaited.push_back(make_report(davp_pkg::ST_NOT_FOUND, '0, '0));
            clear_message();
        end
    endfunction

    function automatic void note_failure(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    // Track configuration, predict on accepted bytes, compare accepted results
    always @(posedge i_clk) begin : watch
        davp_pkg::t_result got;
        davp_pkg::t_result want;
        string             bad;
        if (!i_rst_n) begin
            targets = '0;
            clear_message();
            awaited.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = davp_pkg::t_result'({m_tdata, m_tuser});
                if (awaited.size() == 0) begin
                    note_failure($sformatf("unexpected report st=%0d off=%0d len=%0d",
                                           got.status, got.span_offset, got.span_length));
                end else begin
                    want = awaited.pop_front();
                    bad  = "";
                    if (got.status != want.status) bad = {bad, " status"};
                    if (got.span_offset != want.span_offset) bad = {bad, " span_offset"};
                    if (got.span_length != want.span_length) bad = {bad, " span_length"};
                    if (got.command_flags != want.command_flags) bad = {bad, " command_flags"};
                    if (got.command_code != want.command_code) bad = {bad, " command_code"};
                    if (got.application_id != want.application_id)
                        bad = {bad, " application_id"};
                    if (bad != "")
                        note_failure($sformatf({"mismatch on%s: expected st=%0d off=%0d ",
                            "len=%0d fl=%02h cmd=%06h app=%08h, got st=%0d off=%0d ",
                            "len=%0d fl=%02h cmd=%06h app=%08h"}, bad,
                            want.status, want.span_offset, want.span_length,
                            want.command_flags, want.command_code, want.application_id,
                            got.status, got.span_offset, got.span_length,
                            got.command_flags, got.command_code, got.application_id));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    davp_pkg::CFG_TARGET_CODE:   targets.target_code   = i_cfg_data;
                    davp_pkg::CFG_TARGET_VENDOR: targets.target_vendor = i_cfg_data;
                    davp_pkg::CFG_WHOLE_AVP:     targets.whole_avp     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) parse_body_byte(s_tdata, s_tlast);
        end
        o_pending = awaited.size();
    end

endmodule

// ===== test/diameter_avp_search_core_test.sv =====
// ----------------------------------------------------------------------------
// Diameter AVP search core testbench
// Sends directed and random Diameter message bodies with random gaps on the
// byte stream and random stalls on the result stream, reprograms the search
// targets between message groups, and lets the checker judge every report.
// ----------------------------------------------------------------------------
module diameter_avp_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    int           mismatches;
    int           pending;

    // Stimulus state
    logic [7:0]   body[$];
    logic [31:0]  tgt_code;
    logic [31:0]  tgt_vendor;
    logic         steady = 1'b0;
    int           bytes_sent = 0;

    always #1 i_clk = ~i_clk;

    diameter_avp_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    diameter_avp_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Stall the result stream at random outside the steady stretch
    always @(posedge i_clk) begin
        m_tready <= steady || ($urandom_range(99) >= 16);
    end

    // Hard stop for a hung run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pad_of(input int n);
        return (4 - n % 4) % 4;
    endfunction

    // Zero, all ones or a random word
    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Append the 16-byte message header, big-endian
    function automatic void add_header(input logic [7:0] fl, input logic [23:0] cmd,
                                       input logic [31:0] app);
        body.push_back(fl);
        body.push_back(cmd[23:16]);
        body.push_back(cmd[15:8]);
        body.push_back(cmd[7:0]);
        for (int k = 3; k >= 0; k--) body.push_back(app[8*k +: 8]);
        repeat (8) body.push_back(8'($urandom));
    endfunction

    // Append an AVP header and nval random value bytes
    function automatic void add_avp(input logic [31:0] code, input logic [7:0] fl,
                                    input logic [31:0] vnd, input logic [23:0] len,
                                    input int nval);
        for (int k = 3; k >= 0; k--) body.push_back(code[8*k +: 8]);
        body.push_back(fl);
        for (int k = 2; k >= 0; k--) body.push_back(len[8*k +: 8]);
        if (fl[davp_pkg::VENDOR_BIT])
            for (int k = 3; k >= 0; k--) body.push_back(vnd[8*k +: 8]);
        repeat (nval) body.push_back(8'($urandom));
    endfunction

    // Offer one byte, idling at random first outside the steady stretch, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_body();
        for (int k = 0; k < body.size(); k++) send_byte(body[k], k == body.size() - 1);
        body.delete();
    endtask

    // Stop the byte stream and wait until every report is in
    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Write all three registers while the core is idle
    task automatic program_targets(input logic [31:0] code, input logic [31:0] vnd,
                                   input logic whole);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= davp_pkg::CFG_TARGET_CODE;
        i_cfg_data  <= code;
        @(posedge i_clk);
        i_cfg_index <= davp_pkg::CFG_TARGET_VENDOR;
        i_cfg_data  <= vnd;
        @(posedge i_clk);
        i_cfg_index <= davp_pkg::CFG_WHOLE_AVP;
        i_cfg_data  <= {31'd0, whole};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tgt_code   = code;
        tgt_vendor = vnd;
    endtask

    // Mostly well-formed messages aimed at the targets, some noise and cuts
    task automatic random_message();
        int          n_avp;
        int          r;
        int          hdr;
        int          vlen;
        int          cut;
        logic [7:0]  fl;
        logic [31:0] code;
        logic [31:0] vnd;
        logic [23:0] len;
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(30, 1)) body.push_back(8'($urandom));
            return;
        end
        add_header(8'($urandom), 24'($urandom), $urandom);
        n_avp = $urandom_range(4);
        for (int k = 0; k < n_avp; k++) begin
            code = ($urandom_range(99) < 35) ? tgt_code : pick_word();
            vnd  = $urandom_range(1) ? tgt_vendor : pick_word();
            fl   = 8'($urandom);
            hdr  = fl[davp_pkg::VENDOR_BIT] ? 12 : 8;
            r    = $urandom_range(99);
            if (r < 5) begin
                // length shorter than the AVP header
                add_avp(code, fl, vnd, 24'($urandom_range(hdr - 1)), 0);
                break;
            end else if (r < 10) begin
                // huge length: saturates in whole mode, else runs past the end
                len = (r < 8) ? 24'($urandom_range(24'hFFFFFF, 24'hFFFF00))
                              : 24'($urandom_range(24'hFFFFFF, hdr));
                add_avp(code, fl, vnd, len, $urandom_range(8));
                break;
            end else begin
                vlen = (r < 90) ? $urandom_range(12) : $urandom_range(40, 13);
                add_avp(code, fl, vnd, 24'(hdr + vlen), vlen + pad_of(vlen));
            end
        end
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(6, 1)) body.push_back(8'($urandom));
        // cut the body short, possibly inside a header
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(body.size() - 1, 1);
            while (body.size() > cut) void'(body.pop_back());
        end
    endtask

    initial begin
        int msg;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= davp_pkg::CFG_TARGET_CODE;
        i_cfg_data  <= '0;
        tgt_code   = '0;
        tgt_vendor = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-byte body: cut inside the message header
        body.push_back(8'hFF);
        send_body();

        // Reset targets; the matching header completes on the last byte
        add_header(8'h00, 24'h000000, 32'h0000_0000);
        add_avp(32'h0, 8'h00, 32'h0, 24'd8, 0);
        send_body();

        // Whole mode, all-ones targets: vendor AVP skipped, then a saturated total
        program_targets(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_header(8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        add_avp(32'hFFFF_FFFF, 8'h80, 32'h0000_0001, 24'd13, 4);
        add_avp(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 24'hFFFFFF, 3);
        send_body();

        // Vendor id must not leak into the next AVP; empty value needs no skip
        program_targets(32'h1122_3344, 32'h0, 1'b0);
        add_header(8'h5A, 24'h000110, 32'h0100_0023);
        add_avp(32'h1122_3344, 8'h80, 32'hAABB_CCDD, 24'd12, 0);
        add_avp(32'h1122_3344, 8'h40, 32'h0, 24'd10, 4);
        send_body();

        // Malformed lengths without and with the vendor bit
        add_header(8'($urandom), 24'($urandom), $urandom);
        add_avp(32'h1122_3344, 8'h00, 32'h0, 24'd7, 0);
        send_body();
        add_header(8'($urandom), 24'($urandom), $urandom);
        add_avp(32'h0000_0001, 8'h80, 32'h0000_0002, 24'd11, 2);
        send_body();

        // Cut inside an AVP header
        add_header(8'($urandom), 24'($urandom), $urandom);
        repeat (5) body.push_back(8'($urandom));
        send_body();

        // Random messages, new targets every eight messages, one quiet stretch
        msg = 0;
        while (bytes_sent < 1150) begin
            if (msg % 8 == 0) program_targets(pick_word(), pick_word(), 1'($urandom));
            steady = (msg >= 8 && msg < 16);
            random_message();
            send_body();
            msg++;
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/davp_pkg.sv
design/davp_parser.sv
design/diameter_avp_search_core.sv
test/diameter_avp_search_checker.sv
test/diameter_avp_search_core_test.sv
